[rtl/core/fgr_pkg.sv]
// shared types and constants for the frame gain rider
`timescale 1ns / 1ps
package fgr_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_BITS  = 16;
	localparam int CNT_BITS     = 4;
	localparam int GAIN_BITS    = 24;
	localparam int LEVEL_BITS   = 15;
	localparam int RATE_BITS    = 16;

	localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 24'hFFFFFF;
	localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 24'h010000;

	// register indexes
	localparam logic [1:0] REG_CHANNEL_COUNT  = 2'd0;
	localparam logic [1:0] REG_TARGET_LEVEL   = 2'd1;
	localparam logic [1:0] REG_SMOOTHING_RATE = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// one classified frame waiting for the back end
	typedef struct packed {
		logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] samp;
		logic [CNT_BITS-1:0]                      n;
		logic                                     silent;
	} frame_t;

endpackage

[rtl/core/fgr_front.sv]
// frame intake: lane masking, silence check and a two-entry queue
`timescale 1ns / 1ps
module fgr_front (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  fgr_pkg::sample_t [fgr_pkg::MAX_CHANNELS-1:0] samples,
	input  logic [fgr_pkg::CNT_BITS-1:0]              channel_count,
	output logic                                      q_valid,
	output fgr_pkg::frame_t                           q_frame,
	input  logic                                      q_take
);
	import fgr_pkg::*;

	frame_t       mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	frame_t       entry;
	logic [CNT_BITS-1:0] n_eff;
	logic         push;
	logic         pop;

	always_comb begin
		if (channel_count == '0) begin
			n_eff = CNT_BITS'(1);
		end else if (channel_count > CNT_BITS'(MAX_CHANNELS)) begin
			n_eff = CNT_BITS'(MAX_CHANNELS);
		end else begin
			n_eff = channel_count;
		end
		entry.n = n_eff;
		entry.silent = 1'b1;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			if (CNT_BITS'(i) < n_eff) begin
				entry.samp[i] = samples[i];
			end else begin
				entry.samp[i] = '0;
			end
			if (entry.samp[i] != '0) begin
				entry.silent = 1'b0;
			end
		end
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_take;
	assign q_frame  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/core/fgr_back.sv]
// gain sequencer: rms, target gain, smoothing and per-lane scaling
`timescale 1ns / 1ps
module fgr_back (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_valid,
	input  fgr_pkg::frame_t                           q_frame,
	output logic                                      q_take,
	input  logic [fgr_pkg::LEVEL_BITS-1:0]            target_level,
	input  logic [fgr_pkg::RATE_BITS-1:0]             smoothing_rate,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output fgr_pkg::sample_t [fgr_pkg::MAX_CHANNELS-1:0] outs,
	output logic [fgr_pkg::GAIN_BITS-1:0]             applied_gain,
	output logic                                      silent_frame
);
	import fgr_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_DIV1  = 4'd2;
	localparam logic [3:0] ST_SQRT  = 4'd3;
	localparam logic [3:0] ST_DIV2  = 4'd4;
	localparam logic [3:0] ST_MULT  = 4'd5;
	localparam logic [3:0] ST_CLAMP = 4'd6;
	localparam logic [3:0] ST_SCALE = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	localparam int LANE_BITS = $clog2(MAX_CHANNELS);

	logic [3:0]            state_q;
	sample_t               samp_q [MAX_CHANNELS];
	sample_t               outs_q [MAX_CHANNELS];
	logic                  silent_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [33:0]           acc_q;
	logic [5:0]            cnt_q;
	logic [LANE_BITS-1:0]  lane_q;
	logic [47:0]           num_q;
	logic [24:0]           rem_q;
	logic [23:0]           div_q;
	logic [23:0]           root_q;
	logic [24:0]           srem_q;
	logic [GAIN_BITS-1:0]  t_q;
	logic [24:0]           mag_q;
	logic                  neg_q;
	logic [24:0]           step_q;
	logic [CNT_BITS-1:0]   q_frame_n_q;

	// datapath
	logic signed [31:0]    sq;
	logic [24:0]           rsh;
	logic                  dge;
	logic [25:0]           srs;
	logic [25:0]           trial;
	logic                  sge;
	logic [23:0]           root_n;
	logic [GAIN_BITS-1:0]  t_sat;
	logic signed [25:0]    diff;
	logic [40:0]           sprod;
	logic signed [26:0]    gnew;
	logic signed [26:0]    tt;
	logic signed [26:0]    d2;
	logic signed [26:0]    gcl;
	logic [GAIN_BITS-1:0]  gfin;
	logic signed [40:0]    p;
	logic signed [40:0]    pr;
	logic signed [24:0]    rnd;
	sample_t               scaled;

	always_comb begin
		sq    = samp_q[lane_q] * samp_q[lane_q];
		rsh   = {rem_q[23:0], num_q[47]};
		dge   = rsh >= {1'b0, div_q};
		srs   = {srem_q[23:0], num_q[47:46]};
		trial = {root_q, 2'b01};
		sge   = srs >= trial;
		root_n = {root_q[22:0], sge};
		// quotient sits in num_q after the last step
		if (|num_q[46:23]) begin
			t_sat = GAIN_MAX;
		end else begin
			t_sat = {num_q[22:0], dge};
		end
		diff  = $signed({2'b0, t_sat}) - $signed({2'b0, gain_q});
		sprod = mag_q * smoothing_rate;
		tt    = $signed({3'b0, t_q});
		if (neg_q) begin
			gnew = $signed({3'b0, gain_q}) - $signed({2'b0, step_q});
		end else begin
			gnew = $signed({3'b0, gain_q}) + $signed({2'b0, step_q});
		end
		d2 = gnew - tt;
		if (d2 > 27'sd13107) begin
			gcl = tt + 27'sd13107;
		end else if (d2 < -27'sd13107) begin
			gcl = tt - 27'sd13107;
		end else begin
			gcl = gnew;
		end
		if (gcl < 27'sd0) begin
			gfin = '0;
		end else if (gcl > $signed({3'b0, GAIN_MAX})) begin
			gfin = GAIN_MAX;
		end else begin
			gfin = gcl[GAIN_BITS-1:0];
		end
		// round half up, then saturate to the sample range
		p   = samp_q[lane_q] * $signed({1'b0, gain_q});
		pr  = p + 41'sd32768;
		rnd = pr[40:16];
		if (rnd > 25'sd32767) begin
			scaled = 16'sh7FFF;
		end else if (rnd < -25'sd32768) begin
			scaled = 16'sh8000;
		end else begin
			scaled = rnd[15:0];
		end
	end

	assign q_take       = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign applied_gain = gain_q;
	assign silent_frame = silent_q;

	always_comb begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			outs[i] = outs_q[i];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					samp_q[i] <= q_frame.samp[i];
					outs_q[i] <= q_frame.samp[i];
				end
				silent_q <= q_frame.silent;
				acc_q    <= '0;
				lane_q   <= '0;
			end
			ST_SQ: begin
				acc_q  <= acc_q + {2'b0, $unsigned(sq)};
				lane_q <= lane_q + 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				div_q  <= {20'b0, q_frame_n_q};
				if (lane_q == LANE_BITS'(MAX_CHANNELS - 1)) begin
					num_q <= {acc_q + {2'b0, $unsigned(sq)}, 14'b0};
				end
			end
			ST_DIV1, ST_DIV2: begin
				rem_q  <= dge ? rsh - {1'b0, div_q} : rsh;
				num_q  <= {num_q[46:0], dge};
				cnt_q  <= cnt_q + 1'b1;
				srem_q <= '0;
				root_q <= '0;
				t_q    <= t_sat;
				mag_q  <= diff[25] ? 25'(-diff) : diff[24:0];
				neg_q  <= diff[25];
				if (cnt_q == 6'd47) begin
					cnt_q <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= sge ? 25'(srs - trial) : srs[24:0];
				root_q <= root_n;
				num_q  <= {num_q[45:0], 2'b00};
				cnt_q  <= cnt_q + 1'b1;
				rem_q  <= '0;
				if (cnt_q == 6'd23) begin
					cnt_q <= '0;
					div_q <= (root_n == '0) ? 24'd1 : root_n;
					num_q <= {10'b0, target_level, 23'b0};
				end
			end
			ST_MULT: begin
				step_q <= sprod[40:16];
				lane_q <= '0;
			end
			ST_CLAMP: begin
				lane_q <= '0;
			end
			ST_SCALE: begin
				outs_q[lane_q] <= scaled;
				lane_q <= lane_q + 1'b1;
			end
			ST_DONE: begin
				lane_q <= '0;
			end
			default: begin
				lane_q <= '0;
			end
		endcase
	end

	// channel count of the frame in work
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			q_frame_n_q <= q_frame.n;
		end
	end

	// control and the kept gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q  <= UNITY_GAIN;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= q_frame.silent ? ST_DONE : ST_SQ;
					end
				end
				ST_SQ: begin
					if (lane_q == LANE_BITS'(MAX_CHANNELS - 1)) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (cnt_q == 6'd47) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'd23) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (cnt_q == 6'd47) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					gain_q  <= gfin;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (lane_q == LANE_BITS'(MAX_CHANNELS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/frame_gain_rider_unit.sv]
// top level of the rms frame gain rider
//
// channel   | beat contents                      | handshake
// ----------+------------------------------------+------------------------
// in        | sample_ch0..sample_ch7             | in_valid / in_stall
// out       | out_ch0..out_ch7, applied_gain,    | out_valid / out_stall
//           | silent_frame                       |
// cfg       | cfg_index, cfg_data                | cfg_we, no wait
//
// the back end steps a frame through squaring of the eight lanes, a
// 48-step shared restoring divider run twice (mean square, then target gain),
// a 24-step square root, smoothing and clamp, and scaling of the eight lanes
// a silent frame skips these steps and goes straight to its output beat
// the front queue holds two frames, so two beats are taken while the back is busy
// a finished beat waits in its output registers until out_stall drops
// reset clears the queue, the sequencer and the kept gain (unity)
`timescale 1ns / 1ps
module frame_gain_rider_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] sample_ch0,
	input  logic signed [15:0] sample_ch1,
	input  logic signed [15:0] sample_ch2,
	input  logic signed [15:0] sample_ch3,
	input  logic signed [15:0] sample_ch4,
	input  logic signed [15:0] sample_ch5,
	input  logic signed [15:0] sample_ch6,
	input  logic signed [15:0] sample_ch7,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] out_ch0,
	output logic signed [15:0] out_ch1,
	output logic signed [15:0] out_ch2,
	output logic signed [15:0] out_ch3,
	output logic signed [15:0] out_ch4,
	output logic signed [15:0] out_ch5,
	output logic signed [15:0] out_ch6,
	output logic signed [15:0] out_ch7,
	output logic [23:0] applied_gain,
	output logic        silent_frame,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fgr_pkg::*;

	// configuration registers
	logic [CNT_BITS-1:0]   channel_count_q;
	logic [LEVEL_BITS-1:0] target_level_q;
	logic [RATE_BITS-1:0]  smoothing_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q  <= CNT_BITS'(1);
			target_level_q   <= LEVEL_BITS'(8192);
			smoothing_rate_q <= RATE_BITS'(655);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT:  channel_count_q  <= cfg_data[CNT_BITS-1:0];
				REG_TARGET_LEVEL:   target_level_q   <= cfg_data[LEVEL_BITS-1:0];
				REG_SMOOTHING_RATE: smoothing_rate_q <= cfg_data[RATE_BITS-1:0];
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	sample_t [MAX_CHANNELS-1:0] samples;
	sample_t [MAX_CHANNELS-1:0] outs;
	frame_t  q_frame;
	logic    q_valid;
	logic    q_take;

	assign samples = {sample_ch7, sample_ch6, sample_ch5, sample_ch4,
		sample_ch3, sample_ch2, sample_ch1, sample_ch0};

	// front: masks unused lanes, flags silence, queues the frame
	fgr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.samples       (samples),
		.channel_count (channel_count_q),
		.q_valid       (q_valid),
		.q_frame       (q_frame),
		.q_take        (q_take)
	);

	// back: rms, target gain, smoothing, scaling, output hold
	fgr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_frame        (q_frame),
		.q_take         (q_take),
		.target_level   (target_level_q),
		.smoothing_rate (smoothing_rate_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.outs           (outs),
		.applied_gain   (applied_gain),
		.silent_frame   (silent_frame)
	);

	assign out_ch0 = outs[0];
	assign out_ch1 = outs[1];
	assign out_ch2 = outs[2];
	assign out_ch3 = outs[3];
	assign out_ch4 = outs[4];
	assign out_ch5 = outs[5];
	assign out_ch6 = outs[6];
	assign out_ch7 = outs[7];

endmodule

[sim/tb_frame_gain_rider_unit.sv]
// testbench for the frame gain rider: random frames checked against a gain predictor
`timescale 1ns / 1ps
module tb_frame_gain_rider_unit;
	import fgr_pkg::*;

	typedef struct {
		logic signed [15:0] ch [8];
	} frame_beat_t;

	typedef struct {
		logic signed [15:0] ch [8];
		logic [23:0]        gain;
		logic               silent;
	} gain_result_t;

	// index past the register list
	localparam logic [1:0] REG_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] smp [8];
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] och [8];
	logic [23:0] applied_gain;
	logic silent_frame;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	initial for (int i = 0; i < 8; i++) smp[i] = '0;

	always #4 clk = ~clk;

	frame_gain_rider_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_ch0(smp[0]), .sample_ch1(smp[1]), .sample_ch2(smp[2]),
		.sample_ch3(smp[3]), .sample_ch4(smp[4]), .sample_ch5(smp[5]),
		.sample_ch6(smp[6]), .sample_ch7(smp[7]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_ch0(och[0]), .out_ch1(och[1]), .out_ch2(och[2]), .out_ch3(och[3]),
		.out_ch4(och[4]), .out_ch5(och[5]), .out_ch6(och[6]), .out_ch7(och[7]),
		.applied_gain(applied_gain), .silent_frame(silent_frame),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and kept gain
	logic [3:0]  p_count;
	logic [14:0] p_level;
	logic [15:0] p_rate;
	longint      p_gain;

	frame_beat_t  frames_pending [$];
	gain_result_t gains_expected [$];

	int errors = 0;
	int n_results = 0;
	int n_silent = 0;
	int cycle = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off = 0;

	localparam int CYCLE_LIMIT = 2000000;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// gain rider prediction for one accepted frame, updates the kept gain
	function automatic gain_result_t ride_gain(frame_beat_t f);
		gain_result_t r;
		longint s [8];
		longint unsigned sum = 0, q, rms, tq, mag;
		longint t, diff, stp, p, v;
		int n;
		n = (p_count < 1) ? 1 : (p_count > 8) ? 8 : p_count;
		for (int i = 0; i < 8; i++) begin
			s[i] = (i < n) ? longint'(f.ch[i]) : 0;
			sum += s[i] * s[i];
		end
		if (sum == 0) begin
			for (int i = 0; i < 8; i++) r.ch[i] = s[i][15:0];
			r.gain = p_gain[23:0];
			r.silent = 1'b1;
			return r;
		end
		q = (sum << 14) / n;
		rms = int_sqrt(q);
		if (rms == 0) rms = 1;
		tq = (longint'(p_level) << 23) / rms;
		if (tq > 16777215) tq = 16777215;
		t = tq;
		diff = t - p_gain;
		mag = (diff < 0) ? -diff : diff;
		stp = (mag * p_rate) >> 16;
		p_gain += (diff < 0) ? -stp : stp;
		if (p_gain - t > 13107) p_gain = t + 13107;
		else if (p_gain - t < -13107) p_gain = t - 13107;
		if (p_gain < 0) p_gain = 0;
		if (p_gain > 16777215) p_gain = 16777215;
		for (int i = 0; i < 8; i++) begin
			if (i < n) begin
				p = s[i] * p_gain;
				v = (p + 32768) >>> 16; // ties toward +inf
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
			end else begin
				v = 0;
			end
			r.ch[i] = v[15:0];
		end
		r.gain = p_gain[23:0];
		r.silent = 1'b0;
		return r;
	endfunction

	// driver: one beat at a time, payload held while stalled
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (in_valid && !in_stall) begin
			gains_expected.insert(gains_expected.size(), ride_gain(frames_pending.pop_front()));
		end
		if (in_valid && in_stall) begin
			// hold the offered beat
		end else if (frames_pending.size() > 0 &&
				arst_n && $urandom_range(99) >= send_idle_pct) begin
			// frames_pending front is next; popped above if accepted
			in_valid <= 1'b1;
			for (int i = 0; i < 8; i++) smp[i] <= frames_pending[0].ch[i];
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stall, with a long hold-off counted here
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: compare each beat with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (gains_expected.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				gain_result_t e;
				e = gains_expected.pop_front();
				for (int i = 0; i < 8; i++)
					if (och[i] !== e.ch[i]) begin
						$error("out_ch%0d expected %0d got %0d", i, e.ch[i], och[i]);
						errors++;
					end
				if (applied_gain !== e.gain) begin
					$error("applied_gain expected %0d got %0d", e.gain, applied_gain);
					errors++;
				end
				if (silent_frame !== e.silent) begin
					$error("silent_frame expected %0d got %0d", e.silent, silent_frame);
					errors++;
				end
				n_results++;
				if (e.silent) n_silent++;
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycle > CYCLE_LIMIT) begin
			$display("FAIL frame_gain_rider_unit");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHANNEL_COUNT:  p_count = val[3:0];
			REG_TARGET_LEVEL:   p_level = val[14:0];
			REG_SMOOTHING_RATE: p_rate = val;
			default: ;
		endcase
	endtask

	// wait for the block to drain before touching registers
	task automatic drain();
		while (frames_pending.size() != 0 || in_valid || gains_expected.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return 16'($urandom_range(255) - 128);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic queue_frame(input logic signed [15:0] a, input bit same, input bit zero);
		frame_beat_t f;
		for (int i = 0; i < 8; i++)
			f.ch[i] = zero ? 16'sd0 : same ? a : rand_sample();
		frames_pending.insert(frames_pending.size(), f);
	endtask

	initial begin
		p_count = 4'd1;
		p_level = 15'd8192;
		p_rate = 16'd655;
		p_gain = 65536;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, silent frame, reset settings
		queue_frame(16'sh7FFF, 1, 0);
		queue_frame(16'sh8000, 1, 0);
		queue_frame(16'sd0, 0, 1);
		queue_frame(16'sd1, 1, 0);
		queue_frame(-16'sd1, 1, 0);
		drain();
		// count zero acts as one, above eight acts as eight
		write_reg(REG_CHANNEL_COUNT, 16'd0);
		write_reg(REG_SMOOTHING_RATE, 16'hFFFF);
		write_reg(REG_TARGET_LEVEL, 16'h7FFF);
		queue_frame(16'sd1, 1, 0);
		queue_frame(16'sd0, 0, 1);
		queue_frame(16'sh8000, 1, 0);
		drain();
		write_reg(REG_CHANNEL_COUNT, 16'd15);
		write_reg(REG_TARGET_LEVEL, 16'd0);
		write_reg(REG_SMOOTHING_RATE, 16'd0);
		write_reg(REG_NONE, 16'hFFFF); // index beyond the list is ignored
		queue_frame(16'sh7FFF, 1, 0);
		queue_frame(16'sd3, 0, 0);
		queue_frame(16'sd0, 0, 1);
		drain();
		write_reg(REG_CHANNEL_COUNT, 16'hFFF8);
		write_reg(REG_TARGET_LEVEL, 16'hFFFF);
		write_reg(REG_SMOOTHING_RATE, 16'd32768);
		for (int k = 0; k < 6; k++) queue_frame(16'sd0, 0, 0);
		drain();
		// silent first lane only, noise in unused lanes
		write_reg(REG_CHANNEL_COUNT, 16'd1);
		begin
			frame_beat_t f;
			for (int i = 0; i < 8; i++) f.ch[i] = 16'sh5555;
			f.ch[0] = 0;
			frames_pending.insert(frames_pending.size(), f);
		end
		drain();

		// random phases with varied settings and idling
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 47; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 47; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			write_reg(REG_CHANNEL_COUNT, 16'($urandom_range(15)));
			write_reg(REG_TARGET_LEVEL, (ph == 5) ? 16'd32767 : 16'($urandom()));
			write_reg(REG_SMOOTHING_RATE, (ph == 7) ? 16'd65535 : 16'($urandom()));
			if (ph == 2) hold_off = 3000;
			for (int k = 0; k < 120; k++)
				queue_frame(rand_sample(), $urandom_range(9) == 0, $urandom_range(15) == 0);
			drain();
		end
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (300) @(posedge clk);
		$display("ran %0d frames through the gain rider, %0d of them silent", n_results,
			n_silent);
		$display("covered channel counts 0..15, extreme levels and rates, stalls and gaps");
		if (errors == 0 && gains_expected.size() == 0) begin
			$display("PASS frame_gain_rider_unit");
		end else begin
			$display("FAIL frame_gain_rider_unit");
		end
		$finish;
	end

endmodule
